>>> design/btr_pkg.sv
// Package for the bitmap text renderer: glyph ROM, width table, status codes.
package btr_pkg;

    localparam int GLYPH_ROWS      = 5;
    localparam int DEFAULT_ADVANCE = 5;
    localparam int LETTER_BASE     = 10;
    localparam int PUNCT0_BASE     = 36;
    localparam int PUNCT1_BASE     = 51;
    localparam int PUNCT2_BASE     = 56;
    localparam int GLYPH_COUNT     = 61;

    localparam logic [1:0] ST_DRAWN   = 2'd0;
    localparam logic [1:0] ST_UNSUPP  = 2'd1;
    localparam logic [1:0] ST_OFFSCRN = 2'd2;

    typedef logic [5:0] t_glyph;
    typedef logic [5:0] t_row_bits;

    localparam logic [5:0] GLYPH_ROM [GLYPH_COUNT*GLYPH_ROWS] = '{
        6'h1E,6'h12,6'h12,6'h12,6'h1E, 6'h08,6'h0C,6'h08,6'h08,6'h1C,
        6'h1E,6'h10,6'h1E,6'h02,6'h1E, 6'h1E,6'h10,6'h1E,6'h10,6'h1E,
        6'h12,6'h12,6'h1E,6'h10,6'h10, 6'h1E,6'h02,6'h1E,6'h10,6'h1E,
        6'h1E,6'h02,6'h1E,6'h12,6'h1E, 6'h1E,6'h10,6'h10,6'h10,6'h10,
        6'h1E,6'h12,6'h1E,6'h12,6'h1E, 6'h1E,6'h12,6'h1E,6'h10,6'h1E,
        6'h0C,6'h12,6'h1E,6'h12,6'h12, 6'h0E,6'h12,6'h0E,6'h12,6'h0E,
        6'h0C,6'h12,6'h02,6'h12,6'h0C, 6'h0E,6'h12,6'h12,6'h12,6'h0E,
        6'h1E,6'h02,6'h1E,6'h02,6'h1E, 6'h1E,6'h02,6'h1E,6'h02,6'h02,
        6'h0C,6'h02,6'h1A,6'h12,6'h0C, 6'h12,6'h12,6'h1E,6'h12,6'h12,
        6'h3E,6'h08,6'h08,6'h08,6'h3E, 6'h10,6'h10,6'h10,6'h12,6'h0C,
        6'h12,6'h0A,6'h06,6'h0A,6'h12, 6'h02,6'h02,6'h02,6'h02,6'h1E,
        6'h22,6'h36,6'h2A,6'h22,6'h22, 6'h22,6'h26,6'h2A,6'h32,6'h22,
        6'h0C,6'h12,6'h12,6'h12,6'h0C, 6'h0E,6'h12,6'h0E,6'h02,6'h02,
        6'h1C,6'h22,6'h22,6'h12,6'h2C, 6'h0E,6'h12,6'h0E,6'h12,6'h12,
        6'h1C,6'h02,6'h0C,6'h10,6'h0E, 6'h3E,6'h08,6'h08,6'h08,6'h08,
        6'h12,6'h12,6'h12,6'h12,6'h0C, 6'h22,6'h22,6'h22,6'h14,6'h08,
        6'h22,6'h22,6'h2A,6'h36,6'h22, 6'h12,6'h12,6'h0C,6'h12,6'h12,
        6'h12,6'h12,6'h1E,6'h10,6'h1E, 6'h1E,6'h10,6'h0C,6'h02,6'h1E,
        6'h02,6'h02,6'h02,6'h00,6'h02, 6'h0A,6'h0A,6'h00,6'h00,6'h00,
        6'h14,6'h3E,6'h14,6'h3E,6'h14, 6'h00,6'h00,6'h00,6'h00,6'h00,
        6'h00,6'h12,6'h08,6'h04,6'h12, 6'h00,6'h00,6'h00,6'h00,6'h00,
        6'h02,6'h02,6'h00,6'h00,6'h00, 6'h04,6'h02,6'h02,6'h02,6'h04,
        6'h02,6'h04,6'h04,6'h04,6'h02, 6'h00,6'h0A,6'h04,6'h0A,6'h00,
        6'h00,6'h04,6'h0E,6'h04,6'h00, 6'h00,6'h00,6'h00,6'h04,6'h02,
        6'h00,6'h00,6'h0E,6'h00,6'h00, 6'h00,6'h00,6'h00,6'h00,6'h02,
        6'h00,6'h10,6'h08,6'h04,6'h02,
        6'h00,6'h02,6'h00,6'h02,6'h00, 6'h00,6'h02,6'h00,6'h02,6'h02,
        6'h08,6'h04,6'h02,6'h04,6'h08, 6'h00,6'h0E,6'h00,6'h0E,6'h00,
        6'h02,6'h04,6'h08,6'h04,6'h02,
        6'h06,6'h02,6'h02,6'h02,6'h06, 6'h00,6'h02,6'h04,6'h08,6'h10,
        6'h06,6'h04,6'h04,6'h04,6'h06, 6'h04,6'h0A,6'h00,6'h00,6'h00,
        6'h00,6'h00,6'h00,6'h00,6'h0E
    };

    localparam logic [2:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
        3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,
        3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd6,3'd5,3'd5,3'd5,3'd6,
        3'd6,3'd5,3'd5,3'd6,3'd5,3'd5,3'd6,3'd5,3'd6,3'd6,3'd5,3'd5,3'd5,
        3'd2,3'd4,3'd6,3'd5,3'd5,3'd5,3'd2,3'd3,3'd3,3'd4,3'd4,3'd3,3'd4,
        3'd2,3'd5,
        3'd2,3'd2,3'd4,3'd4,3'd4,
        3'd3,3'd5,3'd3,3'd4,3'd4
    };

    // Map a character byte to its glyph number; valid flag in the top bit.
    function automatic logic [6:0] glyph_of(input logic [7:0] c);
        logic [7:0] u;
        begin
            u = c;
            if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
            if (c >= 8'h30 && c <= 8'h39)      glyph_of = {1'b1, 6'(c - 8'h30)};
            else if (c >= 8'h21 && c <= 8'h2F) glyph_of = {1'b1, 6'(c - 8'h21 + 8'(PUNCT0_BASE))};
            else if (c >= 8'h3A && c <= 8'h3E) glyph_of = {1'b1, 6'(c - 8'h3A + 8'(PUNCT1_BASE))};
            else if (c >= 8'h5B && c <= 8'h5F) glyph_of = {1'b1, 6'(c - 8'h5B + 8'(PUNCT2_BASE))};
            else if (u >= 8'h41 && u <= 8'h5A) glyph_of = {1'b1, 6'(u - 8'h41 + 8'(LETTER_BASE))};
            else                               glyph_of = 7'd0;
        end
    endfunction

endpackage

>>> design/bitmap_text_renderer_unit.sv
// Top level of the bitmap text renderer: glyph lookup and bit-serial pixel scan.
//
// An accepted character passes through a lookup step, a scan of 5*width glyph
// bits and a closing step; a status-only character skips the scan. The scan
// walks the glyph one bit per cycle, shifting the current glyph row out of a
// shift register. Each lit in-frame bit is held back by one pixel so that the
// final request of a character can carry last; the held pixel moves to a
// one-entry output register when the next one is found or when the character
// closes. A stalled output holds the scan. The next character is taken once
// the final request of the current one sits in the output register.
module bitmap_text_renderer_unit
    import btr_pkg::*;
#(
    parameter int FRAME_COLS = 64,
    parameter int FRAME_ROWS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic signed [7:0] i_start_x,
    input  logic signed [7:0] i_start_y,
    input  logic       i_new_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_pixel_x,
    output logic [3:0] o_pixel_y,
    output logic       o_pixel_valid,
    output logic [1:0] o_char_status,
    output logic       o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0]        r_state;
    logic signed [7:0] r_cursor, r_row;
    logic [7:0]        r_code;
    t_glyph            r_glyph;
    logic [2:0]        r_width;
    t_row_bits         r_bits;
    logic [2:0]        r_col;
    logic [2:0]        r_grow;
    logic              r_any;
    logic [1:0]        r_status;

    // Held pixel, waiting to learn whether it is the last one.
    logic [5:0] r_hx;
    logic [3:0] r_hy;

    // Output register.
    logic       r_ovalid;
    logic [5:0] r_px;
    logic [3:0] r_py;
    logic       r_pv;
    logic [1:0] r_ost;
    logic       r_olast;

    logic       out_free;
    logic [6:0] lookup;
    logic [2:0] lk_w;
    logic signed [9:0] cx, cy, cxw, nx;
    logic       off;
    logic signed [9:0] px, py;
    logic       lit, inframe, final_bit;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    assign lookup = glyph_of(r_code);
    assign lk_w   = lookup[6] ? GLYPH_WIDTH[lookup[5:0]] : 3'(DEFAULT_ADVANCE);
    assign cx     = 10'(r_cursor);
    assign cy     = 10'(r_row);
    assign cxw    = cx + 10'(lk_w);
    assign off    = (cxw < 0) || (cx >= 10'(FRAME_COLS)) ||
                    (cy + 10'(GLYPH_ROWS) < 0) || (cy >= 10'(FRAME_ROWS));
    assign nx     = (cxw > 10'sd127) ? 10'sd127 : cxw;

    // Current scan bit position and tests.
    assign px        = cx + 10'(r_col);
    assign py        = cy + 10'(r_grow);
    assign lit       = r_bits[0];
    assign inframe   = (px >= 0) && (px < 10'(FRAME_COLS)) && (py >= 0) &&
                       (py < 10'(FRAME_ROWS));
    assign final_bit = (r_col == r_width - 3'd1) && (r_grow == 3'(GLYPH_ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // Drop a delivered request.
                    if (i_ready) r_ovalid <= 1'b0;
                    if (i_valid) begin
                        r_code <= i_char_code;
                        if (i_new_string) begin
                            r_cursor <= i_start_x;
                            r_row    <= i_start_y;
                        end
                        r_state <= S_LOOK;
                    end
                end
                // Look up glyph, decide scan or status; the cursor advances when the character closes.
                S_LOOK: begin
                    if (i_ready) r_ovalid <= 1'b0;
                    r_glyph  <= lookup[5:0];
                    r_width  <= lk_w;
                    r_col    <= '0;
                    r_grow   <= '0;
                    r_any    <= 1'b0;
                    r_bits   <= GLYPH_ROM[int'(lookup[5:0]) * GLYPH_ROWS];
                    if (!lookup[6]) begin
                        r_status <= ST_UNSUPP;
                        r_state  <= S_STAT;
                    end else if (off) begin
                        r_status <= ST_OFFSCRN;
                        r_state  <= S_STAT;
                    end else begin
                        r_status <= ST_DRAWN;
                        r_state  <= S_SCAN;
                    end
                end
                // Shift one glyph bit per cycle; hold while the output is full.
                S_SCAN: begin
                    if (out_free) begin
                        // Send the held pixel when a newer one replaces it.
                        r_ovalid <= lit && inframe && r_any;
                        if (lit && inframe) begin
                            r_px    <= r_hx;
                            r_py    <= r_hy;
                            r_pv    <= 1'b1;
                            r_ost   <= ST_DRAWN;
                            r_olast <= 1'b0;
                            r_hx    <= px[5:0];
                            r_hy    <= py[3:0];
                            r_any   <= 1'b1;
                        end
                        if (final_bit) begin
                            r_state <= S_STAT;
                        end else if (r_col == r_width - 3'd1) begin
                            r_col  <= '0;
                            r_grow <= r_grow + 3'd1;
                            r_bits <= GLYPH_ROM[int'(r_glyph) * GLYPH_ROWS + int'(r_grow) + 1];
                        end else begin
                            r_col  <= r_col + 3'd1;
                            r_bits <= r_bits >> 1;
                        end
                    end
                end
                // Close the character: send the held pixel as last, or a status request.
                S_STAT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_px     <= r_any ? r_hx : 6'd0;
                        r_py     <= r_any ? r_hy : 4'd0;
                        r_pv     <= r_any;
                        r_ost    <= r_status;
                        r_olast  <= 1'b1;
                        r_any    <= 1'b0;
                        r_cursor <= nx[7:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_valid = r_pv;
    assign o_char_status = r_ost;
    assign o_last        = r_olast;

endmodule

>>> tb/tb_bitmap_text_renderer_unit.sv
// Testbench for the bitmap text renderer: scoreboard class, random and directed characters.
`timescale 1ns / 1ps

class pixel_scoreboard;
    typedef struct packed {
        logic [5:0] px;
        logic [3:0] py;
        logic       pv;
        logic [1:0] status;
        logic       last;
    } pixel_req_t;

    pixel_req_t pending[$];
    logic signed [7:0] cursor_col;
    logic signed [7:0] text_row;
    int errors;
    int chars_seen;
    int pixels_seen;

    function void clear();
        pending.delete();
        cursor_col = '0;
        text_row = '0;
        errors = 0;
        chars_seen = 0;
        pixels_seen = 0;
    endfunction

    // Look a code up: returns glyph number or -1.
    function int glyph_index(logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "!" && c <= "/") return c - "!" + btr_pkg::PUNCT0_BASE;
        if (c >= ":" && c <= ">") return c - ":" + btr_pkg::PUNCT1_BASE;
        if (c >= "[" && c <= "_") return c - "[" + btr_pkg::PUNCT2_BASE;
        if (c >= "a" && c <= "z") u = c - 8'd32;
        if (u >= "A" && u <= "Z") return u - "A" + btr_pkg::LETTER_BASE;
        return -1;
    endfunction

    // Note an accepted character and queue the pixel requests it draws.
    function void note_char(logic [7:0] code, logic signed [7:0] sx,
                            logic signed [7:0] sy, logic ns);
        int x, y, g, w, n, nx, px, py;
        logic [1:0] st;
        logic [5:0] bits;
        pixel_req_t r;
        chars_seen++;
        if (ns) begin
            cursor_col = sx;
            text_row = sy;
        end
        x = cursor_col;
        y = text_row;
        g = glyph_index(code);
        n = 0;
        st = btr_pkg::ST_DRAWN;
        if (g < 0) begin
            st = btr_pkg::ST_UNSUPP;
            w = btr_pkg::DEFAULT_ADVANCE;
        end else begin
            w = btr_pkg::GLYPH_WIDTH[g];
            if (x + w < 0 || x >= 64 || y + 5 < 0 || y >= 16) begin
                st = btr_pkg::ST_OFFSCRN;
            end else begin
                for (int i = 0; i < 5; i++) begin
                    bits = btr_pkg::GLYPH_ROM[g*5 + i];
                    for (int j = 0; j < w; j++) begin
                        px = x + j;
                        py = y + i;
                        if (bits[j] && px >= 0 && px < 64 && py >= 0 && py < 16 && n < 30) begin
                            r = '{px[5:0], py[3:0], 1'b1, btr_pkg::ST_DRAWN, 1'b0};
                            pending.push_back(r);
                            n++;
                        end
                    end
                end
            end
        end
        if (n == 0) begin
            r = '{6'd0, 4'd0, 1'b0, st, 1'b1};
            pending.push_back(r);
        end else begin
            r = pending[$];
            r.last = 1'b1;
            pending[$] = r;
        end
        nx = x + w;
        if (nx > 127) nx = 127;
        cursor_col = nx[7:0];
    endfunction

    // Compare one delivered request with the oldest expectation.
    function void check_pixel(logic [5:0] px, logic [3:0] py, logic pv,
                              logic [1:0] st, logic last);
        pixel_req_t e;
        pixels_seen++;
        if (pending.size() == 0) begin
            $error("unexpected pixel request x=%0d y=%0d", px, py);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (px !== e.px) begin
            $error("pixel_x expected %0d got %0d", e.px, px); errors++;
        end
        if (py !== e.py) begin
            $error("pixel_y expected %0d got %0d", e.py, py); errors++;
        end
        if (pv !== e.pv) begin
            $error("pixel_valid expected %0d got %0d", e.pv, pv); errors++;
        end
        if (st !== e.status) begin
            $error("char_status expected %0d got %0d", e.status, st); errors++;
        end
        if (last !== e.last) begin
            $error("last expected %0d got %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb_bitmap_text_renderer_unit;
    import btr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_char_code = '0;
    logic signed [7:0] i_start_x = '0;
    logic signed [7:0] i_start_y = '0;
    logic i_new_string = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [5:0] o_pixel_x;
    logic [3:0] o_pixel_y;
    logic o_pixel_valid;
    logic [1:0] o_char_status;
    logic o_last;

    pixel_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    bitmap_text_renderer_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count cycles and stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check delivered requests and randomize back pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_pixel(o_pixel_x, o_pixel_y, o_pixel_valid, o_char_status, o_last);
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one character, with a random gap first; valid drops only in a gap.
    task automatic send_char(logic [7:0] code, logic [7:0] sx, logic [7:0] sy, logic ns);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= code;
        i_start_x <= sx;
        i_start_y <= sy;
        i_new_string <= ns;
        do @(posedge i_clk); while (!o_ready);
        sb.note_char(code, sx, sy, ns);
    endtask

    // Pause the sender until every expected request has come.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Pick a code: mostly supported ones, some unsupported.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(9))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(128, 255));
            2, 3:    return 8'($urandom_range(8'h21, 8'h3E));
            4:       return 8'($urandom_range(8'h5B, 8'h5F));
            5, 6:    return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom_range(8'h41, 8'h5A));
        endcase
    endfunction

    // Run a phase of random strings, mostly on screen.
    task automatic random_phase(int n, int idle, int stall);
        logic [7:0] sx, sy;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                sx = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(70) - 8);
                sy = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(22) - 6);
                send_char(pick_code(), sx, sy, 1'b1);
            end else begin
                send_char(pick_code(), 8'($urandom), 8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        sb.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, clipping, off screen, unsupported, overflow.
        send_char("0", 8'sd0, 8'sd0, 1'b1);
        send_char("M", 8'sd0, 8'sd0, 1'b0);
        send_char("w", 8'sd0, 8'sd0, 1'b0);
        send_char(8'h20, 8'sd0, 8'sd0, 1'b0);
        send_char(8'hFF, 8'sd0, 8'sd0, 1'b0);
        send_char(8'h00, 8'sd0, 8'sd0, 1'b0);
        send_char(8'h80, 8'sd0, 8'sd0, 1'b0);
        send_char("#", -8'sd3, -8'sd2, 1'b1);
        send_char("#", 8'sd61, 8'sd13, 1'b1);
        send_char("A", -8'sd128, 8'sd0, 1'b1);
        send_char("A", 8'sd127, -8'sd128, 1'b1);
        send_char("A", 8'sd127, 8'sd127, 1'b1);
        send_char("B", 8'sd120, 8'sd0, 1'b1);
        send_char("%", 8'sd0, 8'sd5, 1'b1);
        send_char("_", 8'sd64, 8'sd0, 1'b1);
        send_char("_", -8'sd6, 8'sd0, 1'b1);
        send_char("[", 8'sd0, 8'sd16, 1'b1);
        send_char("z", 8'sd0, -8'sd5, 1'b1);
        send_char("~", 8'sd0, -8'sd6, 1'b1);
        send_char(">", 8'sd60, 8'sd11, 1'b1);
        send_char("x", -8'sd1, 8'sd15, 1'b1);
        drain();

        random_phase(120, 0, 0);
        random_phase(120, 62, 0);
        drain();
        random_phase(120, 0, 62);
        random_phase(120, 6, 6);
        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d characters and %0d pixel requests",
                 sb.chars_seen, sb.pixels_seen);
        $display("under free flow, sender gaps, receiver stalls and mixed pressure");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
